### hw/rtl/foc_eas_pkg.sv
// Shared types and constants of the electrical angle and speed estimator.
`default_nettype none

package foc_eas_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // register widths
  localparam int PP_W     = 7;
  localparam int OFFSET_W = 16;
  localparam int ALPHA_W  = 17;
  localparam int DTREG_W  = 16;

  // speed field and its saturation limits, 1/65536 turn per second
  localparam int SPEED_W = 33;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 33'h0_FFFF_FFFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 33'h1_0000_0000;

  // microseconds per second, applied one bit per cycle, MSB first
  localparam int SCALE_BITS = 20;
  localparam int SCALE_IDX_W = 5;
  localparam logic [SCALE_BITS-1:0] SPEED_SCALE = 20'd1000000;

  // Q16 unity filter weight
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  // reset values
  localparam logic [PP_W-1:0]    PP_RESET     = 7'd1;
  localparam logic [DTREG_W-1:0] DT_MIN_RESET = 16'd10;
  localparam logic [DTREG_W-1:0] DT_MAX_RESET = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLE_PAIRS   = 3'd0,
    REG_REVERSE_DIR  = 3'd1,
    REG_ZERO_OFFSET  = 3'd2,
    REG_FILTER_ALPHA = 3'd3,
    REG_DT_MIN_US    = 3'd4,
    REG_DT_MAX_US    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_FILT,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/foc_eas_if.sv
// Input and output channel interfaces of the angle and speed estimator.
`default_nettype none

interface foc_eas_in_if #(
  parameter int ANGLE_BITS = 16,
  parameter int DT_BITS    = 16
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] mech_angle;
  logic [DT_BITS-1:0]    interval_us;
  logic                  angle_ok;

  modport source (output valid, mech_angle, interval_us, angle_ok, input ready);
  modport sink   (input valid, mech_angle, interval_us, angle_ok, output ready);
endinterface

interface foc_eas_out_if #(
  parameter int ANGLE_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic [ANGLE_BITS-1:0]            elec_angle;
  logic [foc_eas_pkg::SPEED_W-1:0]  elec_speed;

  modport source (output valid, elec_angle, elec_speed, input ready);
  modport sink   (input valid, elec_angle, elec_speed, output ready);
endinterface

`default_nettype wire

### hw/rtl/foc_electrical_angle_speed.sv
// Electrical angle and low-pass filtered speed estimator, top level.
//
// One input beat gives one output beat. An item with an invalid angle, the first item after
// reset or after a pole pair, direction or offset write, and an item whose interval is out of
// range go from acceptance to the output register with no speed update. An item that updates
// the speed passes a shift-add multiply by one million, a restoring divider that gives one
// quotient bit per cycle over the ANGLE_BITS + 19 bit numerator, a saturation step and a
// shift-add multiply by the filter weight. The block works on one item at a time; the next
// item is taken once the result has moved to the output register, which holds it until the
// sink takes it. There is no clearing pass after reset.
`default_nettype none

module foc_electrical_angle_speed #(
  parameter int ANGLE_BITS = 16,
  parameter int DT_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [foc_eas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [foc_eas_pkg::CFG_DATA_W-1:0] cfg_data,
  foc_eas_in_if.sink                         in_ch,
  foc_eas_out_if.source                      out_ch
);

  // |step| <= half a turn and 1e6 < 2^20
  localparam int NUM_W     = ANGLE_BITS + 19;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int CMP_W     = (DT_BITS > foc_eas_pkg::DTREG_W) ? DT_BITS : foc_eas_pkg::DTREG_W;
  localparam int OFF_EXT_W = (ANGLE_BITS > foc_eas_pkg::OFFSET_W) ? ANGLE_BITS
                                                                   : foc_eas_pkg::OFFSET_W;
  localparam int QX_W      = (NUM_W > 34) ? NUM_W : 34;
  localparam int PROD_W    = ANGLE_BITS + foc_eas_pkg::PP_W;
  localparam int SW        = foc_eas_pkg::SPEED_W;
  localparam int AW        = foc_eas_pkg::ALPHA_W;
  localparam logic [QX_W-1:0] Q_POS_LIM = QX_W'(34'h0_FFFF_FFFF);
  localparam logic [QX_W-1:0] Q_NEG_LIM = QX_W'(34'h1_0000_0000);

  foc_eas_pkg::state_t state, state_next;

  // configuration
  logic [foc_eas_pkg::PP_W-1:0]     pair_count;
  logic                             reverse_dir;
  logic [foc_eas_pkg::OFFSET_W-1:0] zero_offset;
  logic [AW-1:0]                    filter_alpha;
  logic [foc_eas_pkg::DTREG_W-1:0]  dt_min_us;
  logic [foc_eas_pkg::DTREG_W-1:0]  dt_max_us;

  // history
  logic [ANGLE_BITS-1:0] last_angle;
  logic [SW-1:0]         speed_estimate;
  logic                  primed;

  // working registers
  logic [ANGLE_BITS-1:0] mech_r;
  logic [DT_BITS-1:0]    dt_r;
  logic                  ok_r;
  logic [ANGLE_BITS-1:0] res_angle;
  logic                  step_neg;
  logic [ANGLE_BITS-1:0] mag_r;
  logic [NUM_W-1:0]      num_acc;
  logic [NUM_W-1:0]      quo;
  logic [DT_BITS-1:0]    rem;
  logic [CNT_W-1:0]      cnt;
  logic [SW+1:0]         diff;
  logic [SW+1:0]         hi;
  logic [AW-1:0]         lo;
  logic [AW-1:0]         alpha_sh;

  // output register
  logic                  out_valid;
  logic [ANGLE_BITS-1:0] out_angle;
  logic [SW-1:0]         out_speed;

  // combinational datapath
  logic                  in_accept;
  logic                  out_free;
  logic [ANGLE_BITS-1:0] m_dir;
  logic [PROD_W-1:0]     pp_prod;
  logic [OFF_EXT_W-1:0]  off_ext;
  logic [ANGLE_BITS-1:0] angle_now;
  logic [ANGLE_BITS-1:0] d_raw;
  logic [ANGLE_BITS-1:0] d_mag;
  logic                  dt_ok;
  logic [NUM_W-1:0]      num_acc_next;
  logic [DT_BITS:0]      rem_sh;
  logic [DT_BITS:0]      rem_sub;
  logic                  rem_ge;
  logic [QX_W-1:0]       qx;
  logic [SW-1:0]         meas;
  logic [AW-1:0]         alpha_eff;
  logic [SW+1:0]         hi_sum;
  logic [SW+2:0]         corr;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid || out_ch.ready;

  assign m_dir     = reverse_dir ? (~mech_r + ANGLE_BITS'(1)) : mech_r;
  assign pp_prod   = PROD_W'(pair_count) * PROD_W'(m_dir);
  assign off_ext   = OFF_EXT_W'(zero_offset);
  assign angle_now = pp_prod[ANGLE_BITS-1:0] - off_ext[ANGLE_BITS-1:0];
  assign d_raw     = angle_now - last_angle;
  // a half-turn step counts as negative; its magnitude still fits
  assign d_mag     = d_raw[ANGLE_BITS-1] ? (~d_raw + ANGLE_BITS'(1)) : d_raw;
  assign dt_ok     = (dt_r != '0) && (CMP_W'(dt_r) >= CMP_W'(dt_min_us))
                     && (CMP_W'(dt_r) <= CMP_W'(dt_max_us));

  assign num_acc_next = {num_acc[NUM_W-2:0], 1'b0}
                        + (foc_eas_pkg::SPEED_SCALE[cnt[foc_eas_pkg::SCALE_IDX_W-1:0]]
                           ? NUM_W'(mag_r) : NUM_W'(0));

  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dt_r};
  assign rem_sub = rem_sh - {1'b0, dt_r};

  assign qx = QX_W'(quo);
  always_comb begin
    if (step_neg) begin
      meas = (qx > Q_NEG_LIM) ? foc_eas_pkg::SPEED_MIN : (SW'(0) - qx[SW-1:0]);
    end else begin
      meas = (qx > Q_POS_LIM) ? foc_eas_pkg::SPEED_MAX : qx[SW-1:0];
    end
  end

  assign alpha_eff = (filter_alpha > foc_eas_pkg::ALPHA_ONE) ? foc_eas_pkg::ALPHA_ONE
                                                              : filter_alpha;
  assign hi_sum = hi + (alpha_sh[0] ? diff : (SW+2)'(0));
  // full product = hi * 2^17 + lo; floor of it over 2^16 = {hi, lo[16]}
  assign corr   = {hi, lo[AW-1]};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= foc_eas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    unique case (state)
      foc_eas_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_accept) state_next = foc_eas_pkg::ST_PREP;
      end
      foc_eas_pkg::ST_PREP: begin
        state_next = (ok_r && primed && dt_ok) ? foc_eas_pkg::ST_MUL : foc_eas_pkg::ST_DONE;
      end
      foc_eas_pkg::ST_MUL: begin
        if (cnt == '0) state_next = foc_eas_pkg::ST_DIV;
      end
      foc_eas_pkg::ST_DIV: begin
        if (cnt == '0) state_next = foc_eas_pkg::ST_SAT;
      end
      foc_eas_pkg::ST_SAT: begin
        state_next = foc_eas_pkg::ST_FILT;
      end
      foc_eas_pkg::ST_FILT: begin
        if (cnt == '0) state_next = foc_eas_pkg::ST_FIN;
      end
      foc_eas_pkg::ST_FIN: begin
        state_next = foc_eas_pkg::ST_DONE;
      end
      foc_eas_pkg::ST_DONE: begin
        if (out_free) state_next = foc_eas_pkg::ST_IDLE;
      end
      default: state_next = foc_eas_pkg::ST_IDLE;
    endcase
  end

  // configuration and history
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count     <= foc_eas_pkg::PP_RESET;
      reverse_dir    <= 1'b0;
      zero_offset    <= '0;
      filter_alpha   <= foc_eas_pkg::ALPHA_ONE;
      dt_min_us      <= foc_eas_pkg::DT_MIN_RESET;
      dt_max_us      <= foc_eas_pkg::DT_MAX_RESET;
      last_angle     <= '0;
      speed_estimate <= '0;
      primed         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        foc_eas_pkg::REG_POLE_PAIRS: begin
          pair_count     <= cfg_data[foc_eas_pkg::PP_W-1:0];
          last_angle     <= '0;
          speed_estimate <= '0;
          primed         <= 1'b0;
        end
        foc_eas_pkg::REG_REVERSE_DIR: begin
          reverse_dir    <= cfg_data[0];
          last_angle     <= '0;
          speed_estimate <= '0;
          primed         <= 1'b0;
        end
        foc_eas_pkg::REG_ZERO_OFFSET: begin
          zero_offset    <= cfg_data[foc_eas_pkg::OFFSET_W-1:0];
          last_angle     <= '0;
          speed_estimate <= '0;
          primed         <= 1'b0;
        end
        foc_eas_pkg::REG_FILTER_ALPHA: filter_alpha <= cfg_data[AW-1:0];
        foc_eas_pkg::REG_DT_MIN_US:    dt_min_us <= cfg_data[foc_eas_pkg::DTREG_W-1:0];
        foc_eas_pkg::REG_DT_MAX_US:    dt_max_us <= cfg_data[foc_eas_pkg::DTREG_W-1:0];
        default: ;
      endcase
    end else if (state == foc_eas_pkg::ST_PREP && ok_r) begin
      last_angle <= angle_now;
      if (!primed) begin
        primed         <= 1'b1;
        speed_estimate <= '0;
      end
    end else if (state == foc_eas_pkg::ST_FIN) begin
      speed_estimate <= speed_estimate + corr[SW-1:0];
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    unique case (state)
      foc_eas_pkg::ST_IDLE: begin
        if (in_accept) begin
          mech_r <= in_ch.mech_angle;
          dt_r   <= in_ch.interval_us;
          ok_r   <= in_ch.angle_ok;
        end
      end
      foc_eas_pkg::ST_PREP: begin
        res_angle <= ok_r ? angle_now : last_angle;
        step_neg  <= d_raw[ANGLE_BITS-1];
        mag_r     <= d_mag;
        num_acc   <= '0;
        cnt       <= CNT_W'(foc_eas_pkg::SCALE_BITS - 1);
      end
      foc_eas_pkg::ST_MUL: begin
        num_acc <= num_acc_next;
        if (cnt == '0) begin
          quo <= num_acc_next;
          rem <= '0;
          cnt <= CNT_W'(NUM_W - 1);
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
      foc_eas_pkg::ST_DIV: begin
        // one quotient bit per cycle, restoring
        if (rem_ge) begin
          rem <= rem_sub[DT_BITS-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DT_BITS-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
      end
      foc_eas_pkg::ST_SAT: begin
        diff     <= {{2{meas[SW-1]}}, meas} - {{2{speed_estimate[SW-1]}}, speed_estimate};
        hi       <= '0;
        lo       <= '0;
        alpha_sh <= alpha_eff;
        cnt      <= CNT_W'(AW - 1);
      end
      foc_eas_pkg::ST_FILT: begin
        // add on the weight's LSB, then shift the partial product right
        hi       <= {hi_sum[SW+1], hi_sum[SW+1:1]};
        lo       <= {hi_sum[0], lo[AW-1:1]};
        alpha_sh <= {1'b0, alpha_sh[AW-1:1]};
        cnt      <= cnt - CNT_W'(1);
      end
      foc_eas_pkg::ST_FIN: ;
      foc_eas_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == foc_eas_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == foc_eas_pkg::ST_DONE && out_free) begin
      out_angle <= res_angle;
      out_speed <= speed_estimate;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.elec_angle = out_angle;
  assign out_ch.elec_speed = out_speed;

endmodule

`default_nettype wire

### hw/rtl/foc_eas_chk.sv
// Port-level checks of the angle and speed estimator and their binding.
`default_nettype none

module foc_eas_chk #(
  parameter int ANGLE_BITS = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ANGLE_BITS-1:0]           elec_angle,
  input logic [foc_eas_pkg::SPEED_W-1:0] elec_speed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(elec_angle) && $stable(elec_speed))
    else $error("output beat changed while stalled");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle and empty after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while an item is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result shown in the cycle after acceptance");

endmodule

bind foc_electrical_angle_speed foc_eas_chk #(.ANGLE_BITS(ANGLE_BITS)) u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .elec_angle (out_ch.elec_angle),
  .elec_speed (out_ch.elec_speed)
);

`default_nettype wire
